// ===== rtl/sil_pkg.sv =====
// shared types and codes for the sorted id list block
`default_nettype none
package sil_pkg;
   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_REMOVE  = 2'd1;
   localparam logic [1:0] OP_REPLACE = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam int OP_BITS     = 2;
   localparam int CAT_BITS    = 3;
   localparam int FIELD_BITS  = 16;
   localparam int STATUS_BITS = 2;
   localparam int POS_BITS    = 6;
   localparam int LEN_BITS    = 7;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [CAT_BITS-1:0]   category;
      logic [FIELD_BITS-1:0] entity_id;
      logic [FIELD_BITS-1:0] new_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [POS_BITS-1:0]    position;
      logic [LEN_BITS-1:0]    list_length;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/sil_if.sv =====
// valid/ready channel interfaces for requests and results
`default_nettype none
interface sil_req_if;
   import sil_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sil_rsp_if;
   import sil_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sil_id_ram.sv =====
// single port id store, registered read
`default_nettype none
module sil_id_ram #(
   parameter int AW = 9,
   parameter int DW = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] addr,
   input  wire logic [DW-1:0] wdata,
   output logic      [DW-1:0] rdata
);
   logic [DW-1:0] mem [0:(1<<AW)-1];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== rtl/sorted_id_lists_per_category.sv =====
// top level: sorted id lists per category, sequencer over one id memory
`default_nettype none
// One request at a time. Each list sits in a single-port id memory; counts are
// flip-flops. Add walks from the tail toward the front, shifting larger ids up
// one entry per step (read, then write). Remove binary searches (a read, then a
// compare, per probe) then pulls the tail down one entry at a time. Replace
// searches, then bubbles the entry toward the front or back a step at a time.
// A missing id costs only the search. The result register frees once the
// result is taken.
module sorted_id_lists_per_category #(
   parameter int NUM_CATEGORIES = 8,
   parameter int LIST_CAPACITY  = 64,
   parameter int ID_BITS        = 16
) (
   input wire logic clock,
   input wire logic reset,
   sil_req_if.sink  req,
   sil_rsp_if.source rsp
);
   import sil_pkg::*;

   localparam int CB = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
   localparam int IB = $clog2(LIST_CAPACITY);
   localparam int NB = $clog2(LIST_CAPACITY + 1);
   localparam int AW = CB + IB;
   localparam int SB = IB + 2; // signed search bounds

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_AREAD = 4'd1;
   localparam logic [3:0] S_ACHK  = 4'd2;
   localparam logic [3:0] S_FREAD = 4'd3;
   localparam logic [3:0] S_FCHK  = 4'd4;
   localparam logic [3:0] S_RREAD = 4'd5;
   localparam logic [3:0] S_RMOV  = 4'd6;
   localparam logic [3:0] S_PREAD = 4'd7;
   localparam logic [3:0] S_PCHK  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_BACK  = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [NB-1:0]      cnt_ff [NUM_CATEGORIES];
   logic [OP_BITS-1:0] op_ff, op_in;
   logic [CB-1:0]      cat_ff, cat_in;
   logic [ID_BITS-1:0] key_ff, key_in, nid_ff, nid_in;
   logic [NB-1:0]      n_ff, n_in;
   logic [SB-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [IB-1:0]      idx_ff, idx_in;
   logic               dir_ff, dir_in; // replace bubbling toward back
   logic [STATUS_BITS-1:0] st_ff, st_in;
   logic [IB-1:0]      pos_ff, pos_in;
   logic               rv_ff, rv_in;
   rsp_type            rd_ff, rd_in;
   logic               cnt_we;
   logic [NB-1:0]      cnt_wv;

   logic               we;
   logic [IB-1:0]      ma;
   logic [ID_BITS-1:0] wd, rdat;
   logic [SB-1:0]      mid;

   sil_id_ram #(.AW(AW), .DW(ID_BITS)) u_ram (
      .clock(clock), .we(we), .addr({cat_ff, ma}), .wdata(wd), .rdata(rdat)
   );

   assign mid = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;

   always_comb begin
      logic [ID_BITS-1:0] rk, rn;
      rk = ID_BITS'(req.data.entity_id);
      rn = ID_BITS'(req.data.new_id);
      state_in = state_ff; op_in = op_ff; cat_in = cat_ff; key_in = key_ff;
      nid_in = nid_ff; n_in = n_ff; lo_in = lo_ff; hi_in = hi_ff;
      idx_in = idx_ff; dir_in = dir_ff; st_in = st_ff; pos_in = pos_ff;
      rv_in = rv_ff; rd_in = rd_ff;
      cnt_we = 1'b0; cnt_wv = n_ff;
      we = 1'b0; ma = idx_ff; wd = key_ff;
      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in = req.data.op; key_in = rk; nid_in = rn;
               st_in = ST_DONE; pos_in = '0;
               if (32'(req.data.category) >= NUM_CATEGORIES) begin
                  cat_in = '0; st_in = ST_NOT_FOUND; n_in = '0;
                  state_in = S_OUT;
               end else begin
                  cat_in = CB'(req.data.category);
                  n_in = cnt_ff[CB'(req.data.category)];
                  lo_in = '0;
                  hi_in = SB'(cnt_ff[CB'(req.data.category)]) - SB'(1);
                  unique case (req.data.op)
                     OP_ADD: begin
                        if (32'(cnt_ff[CB'(req.data.category)]) >= LIST_CAPACITY) begin
                           st_in = ST_FULL; state_in = S_OUT;
                        end else if (cnt_ff[CB'(req.data.category)] == '0) begin
                           idx_in = '0; state_in = S_BACK;
                        end else begin
                           idx_in = IB'(cnt_ff[CB'(req.data.category)]);
                           state_in = S_AREAD;
                        end
                     end
                     OP_REMOVE, OP_REPLACE: state_in = S_FREAD;
                     default: state_in = S_OUT;
                  endcase
               end
            end
         end
         // add: idx is the hole, compare with entry idx-1
         S_AREAD: begin
            ma = idx_ff - IB'(1); state_in = S_ACHK;
         end
         S_ACHK: begin
            if (key_ff < rdat) begin
               we = 1'b1; wd = rdat;
               idx_in = idx_ff - IB'(1);
               state_in = (idx_ff == IB'(1)) ? S_BACK : S_AREAD;
            end else begin
               state_in = S_BACK;
            end
         end
         // write the key (add) or the new id (replace) into the hole, finish add or replace
         S_BACK: begin
            we = 1'b1; wd = (op_ff == OP_ADD) ? key_ff : nid_ff;
            pos_in = idx_ff;
            if (op_ff == OP_ADD) begin
               n_in = n_ff + NB'(1);
            end
            state_in = S_OUT;
         end
         S_FREAD: begin
            if ($signed(lo_ff) > $signed(hi_ff)) begin
               st_in = ST_NOT_FOUND; state_in = S_OUT;
            end else begin
               ma = IB'(mid); state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            ma = IB'(mid);
            if (rdat == key_ff) begin
               idx_in = IB'(mid);
               if (op_ff == OP_REMOVE) begin
                  state_in = S_RREAD;
               end else begin
                  dir_in = 1'b0; state_in = S_PREAD;
               end
            end else begin
               if (rdat < key_ff) lo_in = mid + SB'(1);
               else hi_in = mid - SB'(1);
               state_in = S_FREAD;
            end
         end
         // remove: pull entry idx+1 down into idx
         S_RREAD: begin
            if (32'(idx_ff) + 1 >= 32'(n_ff)) begin
               n_in = n_ff - NB'(1); state_in = S_OUT;
            end else begin
               ma = idx_ff + IB'(1); state_in = S_RMOV;
            end
         end
         S_RMOV: begin
            we = 1'b1; wd = rdat;
            idx_in = idx_ff + IB'(1); state_in = S_RREAD;
         end
         // replace: hole at idx holds new id logically
         S_PREAD: begin
            if (!dir_ff) begin
               if (idx_ff == '0) begin
                  dir_in = 1'b1;
               end else begin
                  ma = idx_ff - IB'(1); state_in = S_PCHK;
               end
            end else begin
               if (32'(idx_ff) + 1 >= 32'(n_ff)) begin
                  state_in = S_BACK;
               end else begin
                  ma = idx_ff + IB'(1); state_in = S_PCHK;
               end
            end
         end
         S_PCHK: begin
            if (!dir_ff) begin
               if (nid_ff < rdat) begin
                  we = 1'b1; wd = rdat; idx_in = idx_ff - IB'(1);
               end else begin
                  dir_in = 1'b1;
               end
               state_in = S_PREAD;
            end else begin
               if (nid_ff > rdat) begin
                  we = 1'b1; wd = rdat; idx_in = idx_ff + IB'(1);
                  state_in = S_PREAD;
               end else begin
                  state_in = S_BACK;
               end
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rd_in.status = st_ff;
               rd_in.position = (st_ff == ST_DONE && op_ff != OP_REMOVE)
                                ? POS_BITS'(pos_ff) : '0;
               rd_in.list_length = LEN_BITS'(n_ff);
               cnt_we = (st_ff == ST_DONE);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         for (int i = 0; i < NUM_CATEGORIES; i++) cnt_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         if (cnt_we) cnt_ff[cat_ff] <= cnt_wv;
      end
      op_ff <= op_in; cat_ff <= cat_in; key_ff <= key_in; nid_ff <= nid_in;
      n_ff <= n_in; lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in;
      dir_ff <= dir_in; st_ff <= st_in; pos_ff <= pos_in; rd_ff <= rd_in;
   end
endmodule
`default_nettype wire

// ===== sim/tb_sorted_id_lists_per_category.sv =====
// testbench for the sorted id list block: directed and random requests against a predictor
`default_nettype none
module tb_sorted_id_lists_per_category;
   import sil_pkg::*;

   localparam int NUM_CAT  = 8;
   localparam int CAPACITY = 64;
   localparam int WATCHDOG = 20000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sil_req_if req_ch ();
   sil_rsp_if rsp_ch ();

   sorted_id_lists_per_category uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [15:0] id_lists [NUM_CAT][CAPACITY];
   int          id_counts [NUM_CAT];
   rsp_type     expected_rsps [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          hold_rsp = 1'b0;
   int          hold_len = 0;

   function automatic bit search_id(int cat, logic [15:0] key, output int at);
      int lo, hi, mid;
      lo = 0;
      hi = id_counts[cat] - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (id_lists[cat][mid] == key) begin
            at = mid;
            return 1'b1;
         end
         if (id_lists[cat][mid] < key) lo = mid + 1;
         else hi = mid - 1;
      end
      return 1'b0;
   endfunction

   function automatic int bubble_entry(int cat, int idx);
      logic [15:0] t;
      int n;
      n = id_counts[cat];
      while (idx > 0 && id_lists[cat][idx] < id_lists[cat][idx-1]) begin
         t = id_lists[cat][idx];
         id_lists[cat][idx] = id_lists[cat][idx-1];
         id_lists[cat][idx-1] = t;
         idx--;
      end
      while (idx + 1 < n && id_lists[cat][idx] > id_lists[cat][idx+1]) begin
         t = id_lists[cat][idx];
         id_lists[cat][idx] = id_lists[cat][idx+1];
         id_lists[cat][idx+1] = t;
         idx++;
      end
      return idx;
   endfunction

   function automatic rsp_type predict_list_op(req_type r);
      rsp_type res;
      int cat, n, at;
      cat = r.category;
      n = id_counts[cat];
      at = 0;
      res.status = ST_DONE;
      res.position = '0;
      case (r.op)
         OP_ADD: begin
            if (n >= CAPACITY) res.status = ST_FULL;
            else begin
               id_lists[cat][n] = r.entity_id;
               n++;
               id_counts[cat] = n;
               res.position = 6'(bubble_entry(cat, n - 1));
            end
         end
         OP_REMOVE: begin
            if (!search_id(cat, r.entity_id, at)) res.status = ST_NOT_FOUND;
            else begin
               for (int i = at; i < n - 1; i++) id_lists[cat][i] = id_lists[cat][i+1];
               n--;
            end
         end
         OP_REPLACE: begin
            if (!search_id(cat, r.entity_id, at)) res.status = ST_NOT_FOUND;
            else begin
               id_lists[cat][at] = r.new_id;
               res.position = 6'(bubble_entry(cat, at));
            end
         end
         default: ;
      endcase
      id_counts[cat] = n;
      res.list_length = 7'(n);
      return res;
   endfunction

   // sender
   int burst_left = 0;

   task automatic send_request(req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_rsps.push_back(predict_list_op(r));
   endtask

   task automatic send_op(logic [1:0] op, int cat, logic [15:0] id, logic [15:0] nid);
      req_type r;
      r.op = op;
      r.category = 3'(cat);
      r.entity_id = id;
      r.new_id = nid;
      send_request(r);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // pick an id present in the list half the time so searches hit
   function automatic logic [15:0] pick_id(int cat);
      if (id_counts[cat] > 0 && $urandom_range(0, 1))
         return id_lists[cat][$urandom_range(0, id_counts[cat] - 1)];
      return 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40));
   endfunction

   task automatic test_directed();
      send_op(OP_REMOVE, 0, 16'h0000, 16'h0);   // empty list
      send_op(OP_REPLACE, 0, 16'hffff, 16'h0);  // empty list
      send_op(OP_ADD, 0, 16'hffff, 16'h0);
      send_op(OP_REMOVE, 0, 16'h1234, 16'h0);   // one entry, id absent
      send_op(OP_REPLACE, 0, 16'h1234, 16'h5);
      send_op(OP_ADD, 0, 16'h0000, 16'h0);
      send_op(OP_ADD, 0, 16'h8000, 16'h0);
      send_op(OP_ADD, 0, 16'h8000, 16'h0);      // duplicate
      send_op(OP_ADD, 0, 16'h8000, 16'h0);
      send_op(OP_REPLACE, 0, 16'h8000, 16'h0001);
      send_op(OP_REPLACE, 0, 16'h0000, 16'hffff);
      send_op(OP_REPLACE, 0, 16'hffff, 16'h0000);
      send_op(OP_REMOVE, 0, 16'h8000, 16'h0);
      send_op(OP_REMOVE, 0, 16'hffff, 16'h0);
      send_op(OP_UNUSED, 0, 16'hffff, 16'hffff);
      send_op(OP_ADD, 7, 16'h5555, 16'haaaa);
      send_op(OP_REPLACE, 7, 16'h5555, 16'haaaa);
      send_op(OP_REMOVE, 7, 16'haaaa, 16'h5555);
      send_op(OP_UNUSED, 7, 16'h0, 16'h0);
   endtask

   // fill one list past capacity, holding off the receiver at the start
   task automatic test_full_list();
      hold_len = 400;
      hold_rsp = 1'b1;
      for (int i = 0; i < CAPACITY + 3; i++)
         send_op(OP_ADD, 3, 16'($urandom), 16'($urandom));
      send_op(OP_REPLACE, 3, id_lists[3][CAPACITY-1], 16'h0000);
      send_op(OP_REPLACE, 3, id_lists[3][0], 16'hffff);
      send_op(OP_REMOVE, 3, id_lists[3][20], 16'h0);
      send_op(OP_ADD, 3, 16'h0000, 16'h0);
      send_op(OP_ADD, 3, 16'h1, 16'h0);
      wait_drained();
      // empty it again
      while (id_counts[3] > 0)
         send_op(OP_REMOVE, 3, id_lists[3][$urandom_range(0, id_counts[3] - 1)], 16'h0);
      wait_drained();
   endtask

   task automatic test_random(int count);
      req_type r;
      int cat;
      for (int i = 0; i < count; i++) begin
         cat = $urandom_range(0, 7);
         r.category = 3'(cat);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: r.op = id_counts[cat] > 40 ? OP_REMOVE : OP_ADD;
            4, 5, 6: r.op = OP_REMOVE;
            7, 8: r.op = OP_REPLACE;
            default: r.op = 2'($urandom_range(0, 3));
         endcase
         r.entity_id = pick_id(cat);
         r.new_id = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
         send_request(r);
      end
      wait_drained();
   endtask

   // receiver with its own stall pattern and long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            if (hold_len > 0) hold_len--;
            else hold_rsp = 1'b0;
         end else
            rsp_ch.ready <= ($urandom_range(0, 7) < 5);
      end
   end

   // result checker
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_ch.data.status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_ch.data.status);
               errors++;
            end
            if (rsp_ch.data.position !== exp_rsp.position) begin
               $error("position exp %0d got %0d", exp_rsp.position, rsp_ch.data.position);
               errors++;
            end
            if (rsp_ch.data.list_length !== exp_rsp.list_length) begin
               $error("list_length exp %0d got %0d", exp_rsp.list_length,
                      rsp_ch.data.list_length);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no traffic
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("sorted_id_lists_per_category regression: fail");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      for (int c = 0; c < NUM_CAT; c++) id_counts[c] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_full_list();
      test_random(1450);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("sorted_id_lists_per_category regression: pass");
      else
         $display("sorted_id_lists_per_category regression: fail");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/sil_pkg.sv
rtl/sil_if.sv
rtl/sil_id_ram.sv
rtl/sorted_id_lists_per_category.sv
sim/tb_sorted_id_lists_per_category.sv
